// ===== hw/rtl/segi_pkg.sv =====
// Shared widths, word types and constants for the segment intersection block.
package segi_pkg;

   // Coordinates are signed fixed point; every datapath width below follows from this one.
   localparam int COORD_W = 20;
   localparam int DIFF_W = COORD_W + 1;
   localparam int PROD_W = 2 * DIFF_W;
   localparam int CROSS_W = PROD_W + 1;
   localparam int TRIPLE_W = PROD_W + DIFF_W;
   localparam int NUM_W = TRIPLE_W + 3;
   localparam int QUO_W = COORD_W + 1;

   // The queue depth must be a power of two so that the pointers wrap on their own.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef struct packed {
      coord_type a_start_x;
      coord_type a_start_y;
      coord_type a_end_x;
      coord_type a_end_y;
      coord_type b_start_x;
      coord_type b_start_y;
      coord_type b_end_x;
      coord_type b_end_y;
   } seg_pair_type;

   typedef struct packed {
      logic hit;
      coord_type cross_x;
      coord_type cross_y;
      logic degenerate;
   } seg_result_type;

   // Classified word handed from the front end to the divider back end.
   typedef struct packed {
      logic hit;
      logic degenerate;
      logic signed [NUM_W-1:0] num_x;
      logic signed [NUM_W-1:0] num_y;
      logic signed [CROSS_W-1:0] den;
   } seg_job_type;

endpackage

// ===== hw/rtl/segi_if.sv =====
// Valid/ready channel interfaces for segment pairs and intersection results.
interface segi_req_if import segi_pkg::*; ();
   logic valid;
   logic ready;
   coord_type a_start_x;
   coord_type a_start_y;
   coord_type a_end_x;
   coord_type a_end_y;
   coord_type b_start_x;
   coord_type b_start_y;
   coord_type b_end_x;
   coord_type b_end_y;

   modport source (
      output valid, output a_start_x, output a_start_y, output a_end_x, output a_end_y,
      output b_start_x, output b_start_y, output b_end_x, output b_end_y,
      input ready
   );

   modport sink (
      input valid, input a_start_x, input a_start_y, input a_end_x, input a_end_y,
      input b_start_x, input b_start_y, input b_end_x, input b_end_y,
      output ready
   );
endinterface

interface segi_rsp_if import segi_pkg::*; ();
   logic valid;
   logic ready;
   logic hit;
   coord_type cross_x;
   coord_type cross_y;
   logic degenerate;

   modport source (
      output valid, output hit, output cross_x, output cross_y, output degenerate,
      input ready
   );

   modport sink (
      input valid, input hit, input cross_x, input cross_y, input degenerate,
      output ready
   );
endinterface

// ===== hw/rtl/segi_front.sv =====
// Front end: bounding box and straddle classification, denominator and numerators.
module segi_front import segi_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  seg_pair_type in_word,
   output logic         job_valid,
   input  logic         job_ready,
   output seg_job_type  job_word
);

   typedef logic signed [DIFF_W-1:0] diff_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [CROSS_W-1:0] cross_type;
   typedef logic signed [TRIPLE_W-1:0] triple_type;

   typedef struct packed {
      diff_type dxa, dya, dxb, dyb;
      diff_type e13x, e13y, e23x, e23y, e41x, e41y, e42x;
      coord_type x1, x3, y2, y4;
      logic box_reject;
   } geo_type;

   typedef struct packed {
      prod_type c1a, c1b, c2a, c2b, c3a, c3b, c4a, c4b;
      prod_type da, db, m2, m3, m4, m5, m6;
      diff_type dxa, dxb, dyb;
      logic box_reject;
   } prod_stage_type;

   typedef struct packed {
      cross_type c1, c2, c3, c4, den;
      triple_type n1, n2, n3, n4, n5, n6;
      logic box_reject;
   } cube_stage_type;

   function automatic diff_type sub_c(coord_type a, coord_type b);
      return diff_type'(a) - diff_type'(b);
   endfunction

   function automatic prod_type mul_p(diff_type a, diff_type b);
      return prod_type'(a) * prod_type'(b);
   endfunction

   function automatic triple_type mul_t(prod_type a, diff_type b);
      return triple_type'(a) * triple_type'(b);
   endfunction

   function automatic cross_type sub_p(prod_type a, prod_type b);
      return cross_type'(a) - cross_type'(b);
   endfunction

   function automatic coord_type cmax(coord_type a, coord_type b);
      return (a > b) ? a : b;
   endfunction

   function automatic coord_type cmin(coord_type a, coord_type b);
      return (a < b) ? a : b;
   endfunction

   // Both ends strictly on one side: both cross products non-zero with equal signs.
   function automatic logic same_side(cross_type a, cross_type b);
      return (a != '0) && (b != '0) && (a[CROSS_W-1] == b[CROSS_W-1]);
   endfunction

   geo_type        geo_in, geo_ff;
   prod_stage_type prod_in, prod_ff;
   cube_stage_type cube_in, cube_ff;
   seg_job_type    job_in, job_ff;
   logic           geo_v_ff, prod_v_ff, cube_v_ff, job_v_ff;
   logic           geo_adv, prod_adv, cube_adv, job_adv;

   assign job_adv  = !job_v_ff || job_ready;
   assign cube_adv = !cube_v_ff || job_adv;
   assign prod_adv = !prod_v_ff || cube_adv;
   assign geo_adv  = !geo_v_ff || prod_adv;
   assign in_ready = geo_adv;

   always_comb begin
      geo_in.dxa  = sub_c(in_word.a_end_x, in_word.a_start_x);
      geo_in.dya  = sub_c(in_word.a_end_y, in_word.a_start_y);
      geo_in.dxb  = sub_c(in_word.b_end_x, in_word.b_start_x);
      geo_in.dyb  = sub_c(in_word.b_end_y, in_word.b_start_y);
      geo_in.e13x = sub_c(in_word.a_start_x, in_word.b_start_x);
      geo_in.e13y = sub_c(in_word.a_start_y, in_word.b_start_y);
      geo_in.e23x = sub_c(in_word.a_end_x, in_word.b_start_x);
      geo_in.e23y = sub_c(in_word.a_end_y, in_word.b_start_y);
      geo_in.e41x = sub_c(in_word.b_end_x, in_word.a_start_x);
      geo_in.e41y = sub_c(in_word.b_end_y, in_word.a_start_y);
      geo_in.e42x = sub_c(in_word.b_end_x, in_word.a_end_x);
      geo_in.x1   = in_word.a_start_x;
      geo_in.x3   = in_word.b_start_x;
      geo_in.y2   = in_word.a_end_y;
      geo_in.y4   = in_word.b_end_y;
      geo_in.box_reject =
         (cmax(in_word.a_start_x, in_word.a_end_x) < cmin(in_word.b_start_x, in_word.b_end_x)) ||
         (cmax(in_word.a_start_y, in_word.a_end_y) < cmin(in_word.b_start_y, in_word.b_end_y)) ||
         (cmax(in_word.b_start_x, in_word.b_end_x) < cmin(in_word.a_start_x, in_word.a_end_x)) ||
         (cmax(in_word.b_start_y, in_word.b_end_y) < cmin(in_word.a_start_y, in_word.a_end_y));
   end

   always_comb begin
      prod_in.c1a = mul_p(geo_ff.e13x, geo_ff.dyb);
      prod_in.c1b = mul_p(geo_ff.e13y, geo_ff.dxb);
      prod_in.c2a = mul_p(geo_ff.e23x, geo_ff.dyb);
      prod_in.c2b = mul_p(geo_ff.e23y, geo_ff.dxb);
      prod_in.c3a = mul_p(geo_ff.e13y, geo_ff.dxa);
      prod_in.c3b = mul_p(geo_ff.e13x, geo_ff.dya);
      prod_in.c4a = mul_p(geo_ff.e41x, geo_ff.dya);
      prod_in.c4b = mul_p(geo_ff.e41y, geo_ff.dxa);
      prod_in.da  = mul_p(geo_ff.dxa, geo_ff.dyb);
      prod_in.db  = mul_p(geo_ff.dya, geo_ff.dxb);
      prod_in.m2  = mul_p(diff_type'(geo_ff.x3), geo_ff.dyb);
      prod_in.m3  = mul_p(diff_type'(geo_ff.x1), geo_ff.dya);
      prod_in.m4  = mul_p(diff_type'(geo_ff.y2), geo_ff.dxa);
      prod_in.m5  = mul_p(geo_ff.e42x, geo_ff.dya);
      prod_in.m6  = mul_p(diff_type'(geo_ff.y4), geo_ff.dya);
      prod_in.dxa = geo_ff.dxa;
      prod_in.dxb = geo_ff.dxb;
      prod_in.dyb = geo_ff.dyb;
      prod_in.box_reject = geo_ff.box_reject;
   end

   // The y numerator is formed with the same sign as the x numerator, so the back end divides both as they stand.
   always_comb begin
      cube_in.c1  = sub_p(prod_ff.c1a, prod_ff.c1b);
      cube_in.c2  = sub_p(prod_ff.c2a, prod_ff.c2b);
      cube_in.c3  = sub_p(prod_ff.c3a, prod_ff.c3b);
      cube_in.c4  = sub_p(prod_ff.c4a, prod_ff.c4b);
      cube_in.den = sub_p(prod_ff.da, prod_ff.db);
      cube_in.n1  = mul_t(prod_ff.c3a, prod_ff.dxb);
      cube_in.n2  = mul_t(prod_ff.m2, prod_ff.dxa);
      cube_in.n3  = mul_t(prod_ff.m3, prod_ff.dxb);
      cube_in.n4  = mul_t(prod_ff.m4, prod_ff.dyb);
      cube_in.n5  = mul_t(prod_ff.m5, prod_ff.dyb);
      cube_in.n6  = mul_t(prod_ff.m6, prod_ff.dxb);
      cube_in.box_reject = prod_ff.box_reject;
   end

   always_comb begin
      job_in.hit = !cube_ff.box_reject && !same_side(cube_ff.c1, cube_ff.c2) &&
                   !same_side(cube_ff.c3, cube_ff.c4);
      job_in.degenerate = job_in.hit && (cube_ff.den == '0);
      job_in.num_x = NUM_W'(cube_ff.n1) + NUM_W'(cube_ff.n2) - NUM_W'(cube_ff.n3);
      job_in.num_y = NUM_W'(cube_ff.n4) + NUM_W'(cube_ff.n5) - NUM_W'(cube_ff.n6);
      job_in.den = cube_ff.den;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         geo_v_ff  <= 1'b0;
         prod_v_ff <= 1'b0;
         cube_v_ff <= 1'b0;
         job_v_ff  <= 1'b0;
      end else begin
         if (geo_adv) begin
            geo_v_ff <= in_valid;
         end
         if (prod_adv) begin
            prod_v_ff <= geo_v_ff;
         end
         if (cube_adv) begin
            cube_v_ff <= prod_v_ff;
         end
         if (job_adv) begin
            job_v_ff <= cube_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (geo_adv) begin
         geo_ff <= geo_in;
      end
      if (prod_adv) begin
         prod_ff <= prod_in;
      end
      if (cube_adv) begin
         cube_ff <= cube_in;
      end
      if (job_adv) begin
         job_ff <= job_in;
      end
   end

   assign job_valid = job_v_ff;
   assign job_word  = job_ff;

endmodule

// ===== hw/rtl/segi_queue.sv =====
// Short first-in first-out queue that decouples the front end from the divider.
module segi_queue import segi_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  seg_job_type in_word,
   output logic        out_valid,
   input  logic        out_ready,
   output seg_job_type out_word
);

   seg_job_type          slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_AW:0]    count_ff, count_in;
   logic                 push, pop;

   assign in_ready  = (count_ff != (QUEUE_AW + 1)'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_word  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_word;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QUEUE_AW + 1)'(QUEUE_DEPTH))
      else $error("queue fill exceeds its depth");

   a_count_push: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue fill did not grow on a lone push");

   a_count_pop: assert property (@(posedge clock) disable iff (reset)
      pop && !push |=> count_ff == $past(count_ff) - 1'b1)
      else $error("queue fill did not shrink on a lone pop");

endmodule

// ===== hw/rtl/segi_back.sv =====
// Back end: pipelined restoring division of both numerators and result register.
module segi_back import segi_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           job_valid,
   output logic           job_ready,
   input  seg_job_type    job_word,
   output logic           out_valid,
   input  logic           out_ready,
   output seg_result_type out_word
);

   typedef struct packed {
      logic hit;
      logic degenerate;
      logic neg_x;
      logic neg_y;
      logic [NUM_W-1:0] rem_x;
      logic [NUM_W-1:0] rem_y;
      logic [CROSS_W-1:0] div;
      logic [QUO_W-1:0] quo_x;
      logic [QUO_W-1:0] quo_y;
   } div_stage_type;

   div_stage_type  st_ff [QUO_W+1];
   logic           st_v_ff [QUO_W+1];
   logic [QUO_W+1:0] adv;
   div_stage_type  entry_in;
   seg_result_type out_ff, out_in;
   logic           out_v_ff;
   logic [QUO_W-1:0] sq_x, sq_y;
   logic           keep;

   assign adv[QUO_W+1] = !out_v_ff || out_ready;
   assign job_ready = adv[0];

   // Entry stage: magnitudes and quotient signs.
   always_comb begin
      entry_in.hit = job_word.hit;
      entry_in.degenerate = job_word.degenerate;
      entry_in.neg_x = job_word.num_x[NUM_W-1] ^ job_word.den[CROSS_W-1];
      entry_in.neg_y = job_word.num_y[NUM_W-1] ^ job_word.den[CROSS_W-1];
      entry_in.rem_x = job_word.num_x[NUM_W-1] ? -job_word.num_x : job_word.num_x;
      entry_in.rem_y = job_word.num_y[NUM_W-1] ? -job_word.num_y : job_word.num_y;
      entry_in.div = job_word.den[CROSS_W-1] ? -job_word.den : job_word.den;
      entry_in.quo_x = '0;
      entry_in.quo_y = '0;
   end

   assign adv[0] = !st_v_ff[0] || adv[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         st_v_ff[0] <= 1'b0;
      end else if (adv[0]) begin
         st_v_ff[0] <= job_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         st_ff[0] <= entry_in;
      end
   end

   // One quotient bit per stage, most significant first.
   for (genvar k = 1; k <= QUO_W; k++) begin : g_step
      localparam int Bit = QUO_W - k;
      logic [NUM_W-1:0] shifted;
      logic [NUM_W:0]   trial_x, trial_y;
      div_stage_type    step_in;

      assign shifted = NUM_W'(st_ff[k-1].div) << Bit;
      assign trial_x = {1'b0, st_ff[k-1].rem_x} - {1'b0, shifted};
      assign trial_y = {1'b0, st_ff[k-1].rem_y} - {1'b0, shifted};
      assign adv[k]  = !st_v_ff[k] || adv[k+1];

      always_comb begin
         step_in = st_ff[k-1];
         if (!trial_x[NUM_W]) begin
            step_in.rem_x = trial_x[NUM_W-1:0];
            step_in.quo_x[Bit] = 1'b1;
         end
         if (!trial_y[NUM_W]) begin
            step_in.rem_y = trial_y[NUM_W-1:0];
            step_in.quo_y[Bit] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            st_v_ff[k] <= 1'b0;
         end else if (adv[k]) begin
            st_v_ff[k] <= st_v_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv[k]) begin
            st_ff[k] <= step_in;
         end
      end
   end

   // Sign fix-up; a miss or a zero denominator gives a zero point.
   always_comb begin
      sq_x = st_ff[QUO_W].neg_x ? -st_ff[QUO_W].quo_x : st_ff[QUO_W].quo_x;
      sq_y = st_ff[QUO_W].neg_y ? -st_ff[QUO_W].quo_y : st_ff[QUO_W].quo_y;
      keep = st_ff[QUO_W].hit && !st_ff[QUO_W].degenerate;
      out_in.hit = st_ff[QUO_W].hit;
      out_in.degenerate = st_ff[QUO_W].degenerate;
      out_in.cross_x = keep ? sq_x[COORD_W-1:0] : '0;
      out_in.cross_y = keep ? sq_y[COORD_W-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (adv[QUO_W+1]) begin
         out_v_ff <= st_v_ff[QUO_W];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[QUO_W+1]) begin
         out_ff <= out_in;
      end
   end

   assign out_valid = out_v_ff;
   assign out_word  = out_ff;

   a_miss_is_zero: assert property (@(posedge clock) disable iff (reset)
      out_v_ff && !out_ff.hit |->
         (out_ff.cross_x == '0) && (out_ff.cross_y == '0) && !out_ff.degenerate)
      else $error("rejected pair delivered a non-zero result");

endmodule

// ===== hw/rtl/segment_intersection.sv =====
// A pair passes the classifier stages, the queue, the divider stages and the output register.
// Throughput: one pair per cycle unless the result channel stalls; the 21-step quotient pipeline
// and the four-stage classifier each take a new word every cycle, so the rate is set by neither.
// Reset is synchronous and active high; it clears the valid bits and the queue pointers.
// No storage needs a clearing pass, so a pair may be offered in the first cycle after reset.
module segment_intersection import segi_pkg::*; (
   input logic           clock,
   input logic           reset,
   segi_req_if.sink      req_chan,
   segi_rsp_if.source    rsp_chan
);

   // The front end works out the bounding box test, the four cross products whose signs
   // decide the straddle test, the denominator and both cubic numerators. Its last stage
   // reduces all of that to a hit flag, a degenerate flag and three wide integers.
   // A touch (a cross product of zero, or a shared box edge) still counts as a hit.
   seg_pair_type   pair;
   seg_job_type    front_word, queue_word;
   seg_result_type result_word;
   logic           front_valid, front_ready;
   logic           queue_valid, queue_ready;

   assign pair.a_start_x = req_chan.a_start_x;
   assign pair.a_start_y = req_chan.a_start_y;
   assign pair.a_end_x   = req_chan.a_end_x;
   assign pair.a_end_y   = req_chan.a_end_y;
   assign pair.b_start_x = req_chan.b_start_x;
   assign pair.b_start_y = req_chan.b_start_y;
   assign pair.b_end_x   = req_chan.b_end_x;
   assign pair.b_end_y   = req_chan.b_end_y;

   segi_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .in_word   (pair),
      .job_valid (front_valid),
      .job_ready (front_ready),
      .job_word  (front_word)
   );

   // The queue lets the classifier keep accepting words, up to its depth of four, while the
   // divider pipeline is held up by a stalled result channel.
   segi_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_word   (front_word),
      .out_valid (queue_valid),
      .out_ready (queue_ready),
      .out_word  (queue_word)
   );

   // The back end divides both numerators by the denominator, one quotient bit per stage,
   // truncating toward zero. Since a true crossing lies inside both boxes, the quotient
   // magnitude never needs more than one bit above the coordinate width. Its output
   // register holds a waiting result word, which stops new words entering only once every
   // stage behind it holds a word.
   segi_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (queue_valid),
      .job_ready (queue_ready),
      .job_word  (queue_word),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_word  (result_word)
   );

   assign rsp_chan.hit        = result_word.hit;
   assign rsp_chan.cross_x    = result_word.cross_x;
   assign rsp_chan.cross_y    = result_word.cross_y;
   assign rsp_chan.degenerate = result_word.degenerate;

endmodule
